[sv/assert_macros.svh]
// assertion macros included by the event counter unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/fudec_pkg.sv]
// package with types, register map and helpers of the filtered up/down event counter
package fudec_pkg;

    localparam int LEVEL_W  = 8;
    localparam int COUNT_W  = 15;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 2;

    typedef logic [LEVEL_W-1:0]        level_t;
    typedef logic signed [COUNT_W-1:0] count_t;
    typedef logic [REG_IDX_W-1:0]      reg_idx_t;

    localparam reg_idx_t REG_FILTER_MASK    = 2'd0;
    localparam reg_idx_t REG_HIGH_THRESHOLD = 2'd1;
    localparam reg_idx_t REG_LOW_THRESHOLD  = 2'd2;

    localparam level_t FILTER_MASK_RESET    = 8'd255;
    localparam level_t HIGH_THRESHOLD_RESET = 8'd200;
    localparam level_t LOW_THRESHOLD_RESET  = 8'd50;

    // history value forced when a level sits between the thresholds
    localparam level_t HIST_UNDECIDED = 8'd2;

    localparam count_t COUNT_MAX  = 15'sd9999;
    localparam count_t COUNT_MIN  = -15'sd999;
    localparam count_t COUNT_ZERO = 15'sd0;
    localparam count_t COUNT_ONE  = 15'sd1;

    function automatic level_t shift_in(level_t hist, level_t level, level_t hi, level_t lo);
        level_t h;
        h = {hist[LEVEL_W-2:0], 1'b0};
        if (level > hi) begin
            return h | level_t'(1);
        end
        else if (level < lo) begin
            return h;
        end
        else begin
            return HIST_UNDECIDED;
        end
    endfunction

    function automatic logic history_valid(level_t hist, level_t mask);
        return (hist == '0) || ((hist & mask) == mask);
    endfunction

endpackage

[sv/filtered_updown_event_counter_unit.sv]
// filtered up/down event counter: threshold, history filter, edge detect and wrapping count
// a transaction passes through the input register and then the result register
// throughput: one transaction per cycle unless stalled; input register feeds one pass of
// compare, shift and count logic into the result register, which the output stall holds
// reset: asynchronous, clears histories, latched direction and count to zero,
// and sets the filter mask and thresholds to 255, 200 and 50
`include "assert_macros.svh"

module filtered_updown_event_counter_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fudec_pkg::ADDR_W-1:0]         paddr,
    input  logic [fudec_pkg::DATA_W-1:0]         pwdata,
    output logic [fudec_pkg::DATA_W-1:0]         prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  fudec_pkg::level_t                    clock_level,
    input  fudec_pkg::level_t                    dir_level,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output fudec_pkg::count_t                    event_count,
    output logic                                 stop
);

    fudec_pkg::level_t   filter_mask_reg;
    fudec_pkg::level_t   high_threshold_reg;
    fudec_pkg::level_t   low_threshold_reg;
    fudec_pkg::reg_idx_t reg_idx;
    logic                cfg_write;

    logic                s1_valid_reg;
    fudec_pkg::level_t   clock_level_reg;
    fudec_pkg::level_t   dir_level_reg;

    fudec_pkg::level_t   clock_history_reg;
    fudec_pkg::level_t   clock_history_next;
    fudec_pkg::level_t   dir_history_reg;
    fudec_pkg::level_t   dir_history_next;
    fudec_pkg::level_t   last_valid_clock_reg;
    fudec_pkg::level_t   last_valid_clock_next;
    logic                dir_latched_reg;
    logic                dir_latched_next;
    fudec_pkg::count_t   counter_reg;
    fudec_pkg::count_t   counter_next;
    fudec_pkg::count_t   counter_step;

    logic                out_valid_reg;
    fudec_pkg::count_t   event_count_reg;
    logic                stop_reg;

    logic                in_accept;
    logic                out_advance;
    logic                load;
    logic                clock_valid;
    logic                dir_valid;
    logic                falling_edge;

    // configuration port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[fudec_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx)
            fudec_pkg::REG_FILTER_MASK:
            begin
                prdata = fudec_pkg::DATA_W'(filter_mask_reg);
            end
            fudec_pkg::REG_HIGH_THRESHOLD:
            begin
                prdata = fudec_pkg::DATA_W'(high_threshold_reg);
            end
            fudec_pkg::REG_LOW_THRESHOLD:
            begin
                prdata = fudec_pkg::DATA_W'(low_threshold_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mask_reg    <= fudec_pkg::FILTER_MASK_RESET;
            high_threshold_reg <= fudec_pkg::HIGH_THRESHOLD_RESET;
            low_threshold_reg  <= fudec_pkg::LOW_THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                fudec_pkg::REG_FILTER_MASK:
                begin
                    filter_mask_reg <= pwdata[fudec_pkg::LEVEL_W-1:0];
                end
                fudec_pkg::REG_HIGH_THRESHOLD:
                begin
                    high_threshold_reg <= pwdata[fudec_pkg::LEVEL_W-1:0];
                end
                fudec_pkg::REG_LOW_THRESHOLD:
                begin
                    low_threshold_reg <= pwdata[fudec_pkg::LEVEL_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // pipeline handshake
    assign out_advance = !out_valid_reg || !out_stall;
    assign load        = s1_valid_reg && out_advance;
    assign in_stall    = s1_valid_reg && !out_advance;
    assign in_accept   = in_valid && !in_stall;

    // one pass of filter, edge detect and count
    always_comb
    begin
        clock_history_next = fudec_pkg::shift_in(clock_history_reg, clock_level_reg,
                                                 high_threshold_reg, low_threshold_reg);
        dir_history_next   = fudec_pkg::shift_in(dir_history_reg, dir_level_reg,
                                                 high_threshold_reg, low_threshold_reg);
        dir_valid   = fudec_pkg::history_valid(dir_history_next, filter_mask_reg);
        clock_valid = fudec_pkg::history_valid(clock_history_next, filter_mask_reg);

        dir_latched_next = dir_valid ? (dir_history_next != '0) : dir_latched_reg;
        falling_edge     = clock_valid && (last_valid_clock_reg > clock_history_next);
        last_valid_clock_next = clock_valid ? clock_history_next : last_valid_clock_reg;

        if (falling_edge)
        begin
            counter_step = dir_latched_next ? (counter_reg - fudec_pkg::COUNT_ONE)
                                            : (counter_reg + fudec_pkg::COUNT_ONE);
        end
        else
        begin
            counter_step = counter_reg;
        end

        if (counter_step > fudec_pkg::COUNT_MAX)
        begin
            counter_next = fudec_pkg::COUNT_MIN;
        end
        else if (counter_step < fudec_pkg::COUNT_MIN)
        begin
            counter_next = fudec_pkg::COUNT_MAX;
        end
        else
        begin
            counter_next = counter_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            clock_history_reg    <= '0;
            dir_history_reg      <= '0;
            last_valid_clock_reg <= '0;
            dir_latched_reg      <= 1'b0;
            counter_reg          <= fudec_pkg::COUNT_ZERO;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end

            if (load)
            begin
                clock_history_reg    <= clock_history_next;
                dir_history_reg      <= dir_history_next;
                last_valid_clock_reg <= last_valid_clock_next;
                dir_latched_reg      <= dir_latched_next;
                counter_reg          <= counter_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            clock_level_reg <= clock_level;
            dir_level_reg   <= dir_level;
        end
        if (load)
        begin
            event_count_reg <= counter_next;
            stop_reg        <= (counter_next <= fudec_pkg::COUNT_ZERO);
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_count = event_count_reg;
    assign stop        = stop_reg;

    `ASSERT_IMPLIES(a_count_range, out_valid_reg, (event_count_reg <= fudec_pkg::COUNT_MAX) && (event_count_reg >= fudec_pkg::COUNT_MIN), "event count out of range")
    `ASSERT_IMPLIES(a_stop_matches, out_valid_reg, stop_reg == (event_count_reg <= fudec_pkg::COUNT_ZERO), "stop disagrees with count")
    `ASSERT_IMPLIES(a_count_moves_on_load, counter_reg != $past(counter_reg), $past(load), "counter changed without a transaction")
    `ASSERT_ALWAYS(a_stall_needs_item, !in_stall || s1_valid_reg, "input stalled with empty input register")

endmodule
